>>> sv/rgbc_pkg.sv
package rgbc_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int FRAC_BITS     = 16;
  localparam int ROUND_BIAS    = 1 << 15;
  localparam int TAPS          = 9;
  localparam int WEIGHT_W      = 21;
  localparam int KROW_W        = 63;
  localparam int PROD_W        = 38;
  localparam int ROW_W         = 40;
  localparam int SUM_W         = 42;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4,
    REG_DEPTH  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_matte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_matte;
    logic        range_overflow;
    logic        frame_end;
  } out_item_t;

  // channel 0 red .. channel 3 matte
  typedef logic [3:0][15:0] pix_t;
  typedef logic [TAPS-1:0][3:0][15:0] win_t;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } tap_ctl_t;

endpackage

>>> sv/rgbc_ram.sv
module rgbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/rgbc_window.sv
module rgbc_window #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  rgbc_pkg::in_item_t            in_data,
  input  logic [$clog2(MAX_WIDTH):0]    w_eff,
  input  logic [12:0]                   h_eff,
  input  logic                          in16,
  output rgbc_pkg::win_t                taps,
  output rgbc_pkg::tap_ctl_t            tctl
);
  import rgbc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [12:0]   row_r, row_nxt;
  logic          acc;

  logic [CW-1:0] cx;
  logic [12:0]   cy;
  logic [12:0]   row_a;
  logic          emit;
  logic [CW-1:0] ox;
  logic [12:0]   oy;
  logic          fe;
  logic [WW-1:0] cx_inc;

  logic          s1_valid_r;
  logic [CW-1:0] s1_cx_r;
  pix_t          s1_pix_r;
  logic          s1_emit_r;
  logic [CW-1:0] s1_ox_r;
  logic [12:0]   s1_oy_r;
  logic          s1_fe_r;
  logic          fwd_hit_r;
  logic [127:0]  fwd_data_r;

  logic [127:0]  rd_data;
  logic [127:0]  line;
  logic [127:0]  wr_data;
  logic          wr_en;

  win_t          win_r, win_nxt;
  win_t          taps_nxt;
  logic [2:0]    rv, cv;
  pix_t          pix_in;

  win_t          taps_r;
  tap_ctl_t      tctl_r;

  assign acc = in_valid && en;
  assign pix_in = {in_data.in_matte, in_data.in_blue, in_data.in_green, in_data.in_red};

  // position of the accepted item and what it emits
  always_comb begin
    cx    = col_r;
    row_a = row_r;
    if ({1'b0, col_r} >= w_eff) begin
      cx    = '0;
      row_a = row_r + 13'd1;
    end
    if ({1'b0, row_a} > {1'b0, h_eff} + 14'd1) begin
      cx    = '0;
      row_a = '0;
    end
    cy = row_a;
    if (cx == '0) begin
      emit = (cy >= 13'd2) && ({1'b0, cy} < {1'b0, h_eff} + 14'd2);
      ox   = CW'(w_eff - WW'(1));
      oy   = cy - 13'd2;
    end else begin
      emit = (cy >= 13'd1) && ({1'b0, cy} < {1'b0, h_eff} + 14'd1);
      ox   = cx - CW'(1);
      oy   = cy - 13'd1;
    end
    fe = ({1'b0, ox} == w_eff - WW'(1)) && (oy == h_eff - 13'd1);
    cx_inc  = {1'b0, cx} + WW'(1);
    col_nxt = cx;
    row_nxt = cy;
    if ({1'b0, cy} >= {1'b0, h_eff} + 14'd1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cx_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = cy + 13'd1;
    end else begin
      col_nxt = cx_inc[CW-1:0];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: [63:0] previous row, [127:64] row before that
  assign wr_en   = s1_valid_r && en;
  assign line    = fwd_hit_r ? fwd_data_r : rd_data;
  assign wr_data = {line[63:0], s1_pix_r};

  rgbc_ram #(
    .WIDTH (128),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_cx_r),
    .wdata (wr_data),
    .re    (acc),
    .raddr (cx),
    .rdata (rd_data)
  );

  // stage 1 registers, with forwarding of a same-entry write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cx_r    <= cx;
      s1_pix_r   <= pix_in;
      s1_emit_r  <= emit;
      s1_ox_r    <= ox;
      s1_oy_r    <= oy;
      s1_fe_r    <= fe;
      fwd_hit_r  <= wr_en && (s1_cx_r == cx);
      fwd_data_r <= wr_data;
    end
  end

  // window shift and tap masking
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3 + 1] = win_r[r*3+2];
    end
    win_nxt[2] = line[127:64];
    win_nxt[5] = line[63:0];
    win_nxt[8] = s1_pix_r;
    rv[0] = s1_oy_r != 13'd0;
    rv[1] = 1'b1;
    rv[2] = ({1'b0, s1_oy_r} + 14'd1) < {1'b0, h_eff};
    cv[0] = s1_ox_r != '0;
    cv[1] = 1'b1;
    cv[2] = ({1'b0, s1_ox_r} + WW'(1)) < w_eff;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 4; c++) begin
          if (!(rv[i] && cv[j])) begin
            taps_nxt[i*3+j][c] = '0;
          end else if (in16) begin
            taps_nxt[i*3+j][c] = win_nxt[i*3+j][c];
          end else begin
            taps_nxt[i*3+j][c] = {8'h00, win_nxt[i*3+j][c][7:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (wr_en) begin
      win_r <= win_nxt;
    end
  end

  // tap register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tctl_r.valid <= 1'b0;
    end else if (en) begin
      tctl_r.valid <= s1_valid_r && s1_emit_r;
    end
    if (en) begin
      tctl_r.frame_end <= s1_fe_r;
      taps_r           <= taps_nxt;
    end
  end

  assign taps = taps_r;
  assign tctl = tctl_r;

endmodule

>>> sv/rgbc_mac.sv
module rgbc_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rgbc_pkg::win_t            taps,
  input  rgbc_pkg::tap_ctl_t        tctl,
  input  logic [2:0][62:0]          kern,
  input  logic [1:0]                depth_mode,
  output logic                      out_valid,
  output rgbc_pkg::out_item_t       out_data
);
  import rgbc_pkg::*;

  logic signed [PROD_W-1:0] prod_r [4][TAPS];
  logic signed [PROD_W-1:0] prod_nxt [4][TAPS];
  tap_ctl_t                 p_ctl_r;

  logic signed [ROW_W-1:0]  rs_r [4][3];
  logic signed [ROW_W-1:0]  rs_nxt [4][3];
  tap_ctl_t                 r_ctl_r;

  logic                     out_valid_r;
  out_item_t                out_data_r, out_nxt;

  logic [4:0]               sh;
  logic                     in16, out16;

  assign in16  = depth_mode[0];
  assign out16 = depth_mode[1];

  // nine taps times their weights, per channel
  always_comb begin
    logic signed [16:0]         a;
    logic signed [WEIGHT_W-1:0] b;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < TAPS; k++) begin
        a = $signed({1'b0, taps[k][c]});
        b = $signed(kern[k/3][WEIGHT_W*(k%3) +: WEIGHT_W]);
        prod_nxt[c][k] = a * b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // per kernel row sums
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 3; i++) begin
        rs_nxt[c][i] = ROW_W'(prod_r[c][i*3]) + ROW_W'(prod_r[c][i*3+1])
                     + ROW_W'(prod_r[c][i*3+2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r <= rs_nxt;
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r.valid <= 1'b0;
      r_ctl_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      p_ctl_r.valid <= tctl.valid;
      r_ctl_r.valid <= p_ctl_r.valid;
      out_valid_r   <= r_ctl_r.valid;
    end
    if (en) begin
      p_ctl_r.frame_end <= tctl.frame_end;
      r_ctl_r.frame_end <= p_ctl_r.frame_end;
    end
  end

  // final sum, rounding, floor shift, range check
  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] r;
    logic [15:0]             ch [4];
    logic                    ovf;
    sh  = 5'(FRAC_BITS + 8 * int'(in16) - 8 * int'(out16));
    ovf = 1'b0;
    for (int c = 0; c < 4; c++) begin
      s = SUM_W'(rs_r[c][0]) + SUM_W'(rs_r[c][1]) + SUM_W'(rs_r[c][2])
        + SUM_W'(ROUND_BIAS);
      r = s >>> sh;
      if (s[SUM_W-1]) begin
        ovf = 1'b1;
      end else if (out16 && (r[SUM_W-1:16] != '0)) begin
        ovf = 1'b1;
      end else if (!out16 && (r[SUM_W-1:8] != '0)) begin
        ovf = 1'b1;
      end
      ch[c] = out16 ? r[15:0] : {8'h00, r[7:0]};
    end
    out_nxt.out_red        = ch[0];
    out_nxt.out_green      = ch[1];
    out_nxt.out_blue       = ch[2];
    out_nxt.out_matte      = ch[3];
    out_nxt.range_overflow = ovf;
    out_nxt.frame_end      = r_ctl_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/rgbm_3x3_convolution.sv
// a result passes the stage 1, tap, product, row sum and output registers after the
// transfer of the item that completes its window (one row and one pixel later)
// throughput: one item per cycle unless stalled; one line store read and write a cycle
// reset: counters, window and registers to their reset values; the line store is not
// cleared, its stale entries reach only taps that the border masking zeroes
module rgbm_3x3_convolution #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [62:0]          cfg_data
);
  import rgbc_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH) + 1;

  logic [11:0]      width_r;
  logic [12:0]      height_r;
  logic [62:0]      ktop_r, kmid_r, kbot_r;
  logic [1:0]       depth_r;

  logic [WW-1:0]    w_eff;
  logic [12:0]      h_eff;
  logic             en;
  win_t             taps;
  tap_ctl_t         tctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd1;
      height_r <= 13'd1;
      ktop_r   <= '0;
      kmid_r   <= 63'd65536;
      kbot_r   <= '0;
      depth_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[11:0];
        REG_HEIGHT: height_r <= cfg_data[12:0];
        REG_KTOP:   ktop_r   <= cfg_data;
        REG_KMID:   kmid_r   <= cfg_data;
        REG_KBOT:   kbot_r   <= cfg_data;
        REG_DEPTH:  depth_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped: width to what the line store holds, height to MAX_HEIGHT, zero to one
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = 13'd1;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // whole pipeline moves unless a result is held at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rgbc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .in16     (depth_r[0]),
    .taps     (taps),
    .tctl     (tctl)
  );

  rgbc_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .taps       (taps),
    .tctl       (tctl),
    .kern       ({kbot_r, kmid_r, ktop_r}),
    .depth_mode (depth_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // input held back only while a result waits at the output
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // no result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

>>> dv/rgbm_checker.sv
`timescale 1ns / 1ps

module rgbm_checker #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rgbc_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rgbc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [62:0]          cfg_data,
  input  logic                 final_check,
  output int                   fails,
  output int                   pending
);
  import rgbc_pkg::*;

  // shadow registers
  logic [11:0] img_w;
  logic [12:0] img_h;
  logic [62:0] krow [3];
  logic [1:0]  depth;

  // shadow pixel pipeline
  logic [63:0] lines [2*MAX_WIDTH];
  logic [63:0] win [9];
  int          col, row;
  bit          leftovers_done;

  out_item_t   expected_pixels [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic out_item_t convolve_at(int ox, int oy, int w, int h, int base);
    out_item_t   r;
    longint      wt [9];
    bit          ok [9];
    longint      s, rs, p, omask;
    logic [20:0] f;
    int          sh, tx, ty;
    bit          in16, out16, ovf;
    logic [15:0] ch [4];
    in16  = depth[0];
    out16 = depth[1];
    sh    = 16 + 8 * int'(in16) - 8 * int'(out16);
    omask = out16 ? 64'hFFFF : 64'hFF;
    ovf   = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tx = ox - 1 + j;
        ty = oy - 1 + i;
        f = krow[i][21*j +: 21];
        wt[i*3+j] = longint'($signed(f));
        ok[i*3+j] = tx >= 0 && tx < w && ty >= 0 && ty < h && base + j < 3;
      end
    end
    for (int c = 0; c < 4; c++) begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (ok[i*3+j]) begin
            p = longint'({48'd0, win[i*3+base+j][16*c +: 16]});
            if (!in16) p = p & 64'hFF;
            s += p * wt[i*3+j];
          end
        end
      end
      s += longint'(1) << 15;
      rs = s >>> sh;
      if (s < 0 || rs > omask) ovf = 1;
      ch[c] = 16'(rs & omask);
    end
    r.out_red        = ch[0];
    r.out_green      = ch[1];
    r.out_blue       = ch[2];
    r.out_matte      = ch[3];
    r.range_overflow = ovf;
    r.frame_end      = (ox == w - 1 && oy == h - 1);
    return r;
  endfunction

  function automatic void shift_window(int cx, logic [63:0] pix);
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = lines[MAX_WIDTH + cx];
    win[5] = lines[cx];
    win[8] = pix;
    lines[MAX_WIDTH + cx] = lines[cx];
    lines[cx] = pix;
  endfunction

  // advance the raster position by one pixel and predict its output, if any
  function automatic void predict_pixel(in_item_t d, output bit got, output out_item_t r);
    int          w, h, cx, cy;
    logic [63:0] pix;
    w = int'(img_w);
    h = int'(img_h);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row > h + 1) begin
      row = 0;
      col = 0;
    end
    cx  = col;
    cy  = row;
    pix = {d.in_matte, d.in_blue, d.in_green, d.in_red};
    got = 0;
    if (cx == 0) begin
      // first pixel of a row completes the last pixel of the row two above
      if (cy >= 2 && cy - 2 < h) begin
        r   = convolve_at(w - 1, cy - 2, w, h, 1);
        got = 1;
      end
      shift_window(cx, pix);
    end else begin
      shift_window(cx, pix);
      if (cy >= 1 && cy - 1 < h) begin
        r   = convolve_at(cx - 1, cy - 1, w, h, 0);
        got = 1;
      end
    end
    if (cy >= h + 1) begin
      col = 0;
      row = 0;
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
    end
  endfunction

  // watch the three ports
  always @(posedge clk) begin
    out_item_t e, r;
    bit        got;
    if (!rst_n) begin
      img_w   = 12'd1;
      img_h   = 13'd1;
      krow[0] = '0;
      krow[1] = 63'd65536;
      krow[2] = '0;
      depth   = '0;
      for (int i = 0; i < 2*MAX_WIDTH; i++) lines[i] = '0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      col = 0;
      row = 0;
      fails   = 0;
      pending <= 0;
      leftovers_done = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH:  img_w = cfg_data[11:0];
          REG_HEIGHT: img_h = cfg_data[12:0];
          REG_KTOP:   krow[0] = cfg_data;
          REG_KMID:   krow[1] = cfg_data;
          REG_KBOT:   krow[2] = cfg_data;
          REG_DEPTH:  depth = cfg_data[1:0];
          default: ;
        endcase
      end
      // result transfer
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = expected_pixels.pop_front();
          if (out_data.out_red !== e.out_red)
            report($sformatf("red %h, expected %h", out_data.out_red, e.out_red));
          if (out_data.out_green !== e.out_green)
            report($sformatf("green %h, expected %h", out_data.out_green, e.out_green));
          if (out_data.out_blue !== e.out_blue)
            report($sformatf("blue %h, expected %h", out_data.out_blue, e.out_blue));
          if (out_data.out_matte !== e.out_matte)
            report($sformatf("matte %h, expected %h", out_data.out_matte, e.out_matte));
          if (out_data.range_overflow !== e.range_overflow)
            report($sformatf("range_overflow %b, expected %b",
                             out_data.range_overflow, e.range_overflow));
          if (out_data.frame_end !== e.frame_end)
            report($sformatf("frame_end %b, expected %b", out_data.frame_end, e.frame_end));
        end
      end
      // input transfer
      if (in_valid && !in_stall) begin
        predict_pixel(in_data, got, r);
        if (got) expected_pixels.push_back(r);
      end
      if (final_check && !leftovers_done) begin
        leftovers_done = 1;
        foreach (expected_pixels[i]) report("expected result never came");
        expected_pixels.delete();
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rgbc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [62:0] cfg_data;
  logic        final_check;
  int          fails;
  int          pending;

  bit          hold_req;
  int          burst_left;
  int          sent;

  rgbm_3x3_convolution u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgbm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .final_check (final_check),
    .fails       (fails),
    .pending     (pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver stall pattern, with one long hold-off when the stimulus requests it
  initial begin
    int mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 400);
      for (int i = 0; i < span && !hold_req; i++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          2: out_stall = (i % 4 == 3);
          default: out_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
        hold_req = 0;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [62:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // wait until every expected pixel is out, then let the pipeline settle
  task automatic wait_drained();
    in_valid = 1'b0;
    for (int i = 0; i < 200000 && pending != 0; i++) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [20:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      2: return 21'($urandom_range(0, 65536));
      3: return -21'($urandom_range(0, 65536));
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] pick_row();
    return {pick_weight(), pick_weight(), pick_weight()};
  endfunction

  task automatic set_frame(input logic [11:0] w, input logic [12:0] h,
                           input logic [62:0] kt, input logic [62:0] km,
                           input logic [62:0] kb, input logic [1:0] dm);
    write_reg(REG_WIDTH, 63'(w));
    write_reg(REG_HEIGHT, 63'(h));
    write_reg(REG_KTOP, kt);
    write_reg(REG_KMID, km);
    write_reg(REG_KBOT, kb);
    write_reg(REG_DEPTH, 63'(dm));
  endtask

  // one pixel transfer; the sender idles between bursts
  task automatic send_pixel(input in_item_t d);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    in_data  = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  function automatic in_item_t rand_pixel();
    return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  // a whole frame plus its drain items
  task automatic send_frame(input logic [11:0] w, input logic [12:0] h, input bit pause_mid);
    int we, he, total;
    we = (w == 0) ? 1 : (w > 2048 ? 2048 : int'(w));
    he = (h == 0) ? 1 : (h > 4096 ? 4096 : int'(h));
    total = we * he + we + 1;
    for (int i = 0; i < total; i++) begin
      if (pause_mid && i == total / 2) wait_drained();
      send_pixel(rand_pixel());
    end
  endtask

  initial begin
    in_item_t    corner [4];
    logic [11:0] w;
    logic [12:0] h;
    int          nframe;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    final_check = 1'b0;
    hold_req    = 0;
    burst_left  = 0;
    sent        = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extreme pixels and weights, 3x3 frame in 8-bit mode
    corner[0] = '0;
    corner[1] = '1;
    corner[2] = {4{16'hAAAA}};
    corner[3] = {4{16'h5555}};
    set_frame(12'd3, 13'd3, {21'h100000, 21'h0FFFFF, 21'h010000},
              {21'h0FFFFF, 21'h100000, 21'h1F0000},
              {21'h008000, 21'h000000, 21'h100000}, 2'd0);
    for (int i = 0; i < 13; i++) send_pixel(corner[i % 4]);
    wait_drained();
    // directed: 2x2 frame, 16-bit in and out
    set_frame(12'd2, 13'd2, {3{21'h010000}}, {3{21'h010000}}, {3{21'h1F0000}}, 2'd3);
    for (int i = 0; i < 7; i++) send_pixel(corner[(i + 1) % 4]);
    wait_drained();

    // random frames
    nframe = 0;
    while (sent < 1850) begin
      w = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(9, 40)) : 12'($urandom_range(1, 8));
      h = 13'($urandom_range(1, 6));
      case (nframe)
        3: begin
          w = 12'd24;
          h = 13'd12;
        end
        6: begin
          w = 12'd40;
          h = 13'd1;
        end
        9: begin
          w = 12'd1;
          h = 13'd60;
        end
        12: begin
          w = 12'd0;
          h = 13'd0;
        end
        default: ;
      endcase
      set_frame(w, h, pick_row(), pick_row(), pick_row(), 2'($urandom_range(0, 3)));
      if (nframe == 3) hold_req = 1;
      send_frame(w, h, nframe == 4);
      wait_drained();
      nframe++;
    end

    final_check = 1'b1;
    repeat (3) @(negedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
